FILE: rtl/ctspf_pkg.sv
// Shared types, constants and lookup functions for the counter to segment pixel frame block.
// Used by every module under rtl; depends on nothing else.
`default_nettype none

package ctspf_pkg;

  // Geometry of the strip.
  localparam int PIXELS_PER_DIGIT = 15;
  localparam int DIGIT_COUNT      = 4;
  localparam int FRAME_PIXELS     = 60;
  localparam int QUEUE_DEPTH      = 2;

  // Field widths.
  localparam int COUNT_W = 16;
  localparam int COLOR_W = 24;
  localparam int INDEX_W = 6;
  localparam int CFG_IDX_W = 2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 16'd9999;

  // Reciprocal of ten, scaled by 2^19; exact for values below 16384.
  localparam logic [15:0] RECIP_TEN   = 16'd52429;
  localparam int          RECIP_SHIFT = 19;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_COLOR_OPEN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLOR_CLOSED = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLOR_NOTICE = 2'd2;

  localparam logic [COLOR_W-1:0] RESET_COLOR_OPEN   = 24'h00FF00;
  localparam logic [COLOR_W-1:0] RESET_COLOR_CLOSED = 24'hFF0000;
  localparam logic [COLOR_W-1:0] RESET_COLOR_NOTICE = 24'hFFFF00;

  // Pattern bits: 7 = dp, 6 = a, 5 = b, 4 = c, 3 = d, 2 = e, 1 = f, 0 = g.
  localparam logic [7:0] PAT_BLANK  = 8'h00;
  localparam logic [7:0] PAT_DASH   = 8'h01;
  localparam logic [7:0] PAT_EQUALS = 8'h09;
  localparam logic [7:0] PAT_N      = 8'h15;
  localparam logic [7:0] PAT_H      = 8'h37;
  localparam logic [7:0] PAT_DP     = 8'h80;

  // Color chosen for one digit slot.
  typedef enum logic [1:0] {
    CS_OPEN,
    CS_CLOSED,
    CS_NOTICE
  } color_sel_t;

  // One frame as handed from the front end to the pixel serializer.
  typedef struct packed {
    logic [DIGIT_COUNT-1:0][7:0] pat;
    color_sel_t [DIGIT_COUNT-1:0] csel;
  } frame_t;

  // Front end sequencer states.
  typedef enum logic [1:0] {
    FR_IDLE,
    FR_CONV,
    FR_PUSH
  } front_state_t;

  // Segment pattern of a decimal digit.
  function automatic logic [7:0] digit_pattern(input logic [3:0] d);
    logic [7:0] p;
    case (d)
      4'd0:    p = 8'h7E;
      4'd1:    p = 8'h30;
      4'd2:    p = 8'h6D;
      4'd3:    p = 8'h79;
      4'd4:    p = 8'h33;
      4'd5:    p = 8'h5B;
      4'd6:    p = 8'h5F;
      4'd7:    p = 8'h70;
      4'd8:    p = 8'h7F;
      4'd9:    p = 8'h7B;
      default: p = PAT_BLANK;
    endcase
    return p;
  endfunction

  // Pattern bit lit by each pixel offset inside a digit.
  function automatic logic [2:0] offset_bit(input logic [3:0] off);
    logic [2:0] b;
    case (off)
      4'd0, 4'd1:   b = 3'd4;
      4'd2:         b = 3'd7;
      4'd3, 4'd4:   b = 3'd3;
      4'd5, 4'd6:   b = 3'd2;
      4'd7, 4'd8:   b = 3'd0;
      4'd9, 4'd10:  b = 3'd5;
      4'd11, 4'd12: b = 3'd6;
      4'd13, 4'd14: b = 3'd1;
      default:      b = 3'd0;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/ctspf_front.sv
// Front end: accepts a count word, splits it into decimal digits and builds the digit patterns.
// Depends on ctspf_pkg.
`default_nettype none

module ctspf_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [ctspf_pkg::COUNT_W-1:0] count_value,
  input  wire logic                          is_open,
  output logic                               push,
  output ctspf_pkg::frame_t                  push_frame,
  input  wire logic                          q_full
);

  ctspf_pkg::front_state_t state, state_next;

  logic [13:0] n;
  logic [1:0]  step;
  logic [3:0]  dig [ctspf_pkg::DIGIT_COUNT];
  logic        neg, over, gt9, gt99, gt999, open;

  logic [29:0] prod;
  logic [13:0] quot;
  logic [3:0]  rem;
  logic        accept;

  assign accept = s_tvalid && s_tready;

  // Divide by ten through the scaled reciprocal.
  assign prod = n * ctspf_pkg::RECIP_TEN;
  assign quot = {3'b000, prod[29:ctspf_pkg::RECIP_SHIFT]};
  assign rem  = 4'(n - ((quot << 3) + (quot << 1)));

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ctspf_pkg::FR_IDLE: if (accept) state_next = ctspf_pkg::FR_CONV;
      ctspf_pkg::FR_CONV: if (step == 2'd3) state_next = ctspf_pkg::FR_PUSH;
      ctspf_pkg::FR_PUSH: if (!q_full) state_next = ctspf_pkg::FR_IDLE;
      default:            state_next = ctspf_pkg::FR_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    s_tready = 1'b0;
    push     = 1'b0;
    case (state)
      ctspf_pkg::FR_IDLE: s_tready = 1'b1;
      ctspf_pkg::FR_PUSH: push = !q_full;
      default: begin
        s_tready = 1'b0;
        push     = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ctspf_pkg::FR_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Capture and classify the word, then peel one digit a cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= 2'd0;
    end else if (accept) begin
      step  <= 2'd0;
      n     <= count_value[13:0];
      neg   <= count_value[15];
      over  <= !count_value[15] && (count_value > ctspf_pkg::COUNT_MAX);
      gt9   <= count_value > 16'd9;
      gt99  <= count_value > 16'd99;
      gt999 <= count_value > 16'd999;
      open  <= is_open;
    end else if (state == ctspf_pkg::FR_CONV) begin
      dig[step] <= rem;
      n         <= quot;
      step      <= step + 2'd1;
    end
  end

  // Assemble the frame description from the digits and the range flags.
  always_comb begin
    logic [7:0]               t;
    ctspf_pkg::color_sel_t    dc;
    t  = neg ? ctspf_pkg::PAT_DASH : ctspf_pkg::PAT_H;
    dc = open ? ctspf_pkg::CS_OPEN : ctspf_pkg::CS_CLOSED;
    if (neg || over) begin
      push_frame.pat  = {ctspf_pkg::PAT_BLANK, t, t, ctspf_pkg::PAT_BLANK};
      push_frame.csel = {4{ctspf_pkg::CS_NOTICE}};
    end else begin
      push_frame.pat[0]  = ctspf_pkg::digit_pattern(dig[0]) |
                           (open ? ctspf_pkg::PAT_BLANK : ctspf_pkg::PAT_DP);
      push_frame.csel[0] = dc;
      push_frame.pat[1]  = gt9 ? ctspf_pkg::digit_pattern(dig[1]) : ctspf_pkg::PAT_BLANK;
      push_frame.csel[1] = dc;
      push_frame.pat[2]  = gt99 ? ctspf_pkg::digit_pattern(dig[2]) : ctspf_pkg::PAT_EQUALS;
      push_frame.csel[2] = gt99 ? dc : ctspf_pkg::CS_NOTICE;
      push_frame.pat[3]  = gt999 ? ctspf_pkg::digit_pattern(dig[3]) : ctspf_pkg::PAT_N;
      push_frame.csel[3] = gt999 ? dc : ctspf_pkg::CS_NOTICE;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/ctspf_queue.sv
// Short FIFO of frame descriptions between the front end and the pixel serializer.
// Depends on ctspf_pkg.
`default_nettype none

module ctspf_queue #(
  parameter int DEPTH = ctspf_pkg::QUEUE_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  ctspf_pkg::frame_t      push_frame,
  output logic                   full,
  input  wire logic              pop,
  output logic                   head_valid,
  output ctspf_pkg::frame_t      head_frame
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  ctspf_pkg::frame_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] fill;

  assign full       = (fill == CNT_W'(DEPTH));
  assign head_valid = (fill != '0);
  assign head_frame = entries[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_frame;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/ctspf_back.sv
// Pixel serializer: walks the head frame's 60 pixels, one word per unstalled cycle.
// Depends on ctspf_pkg.
`default_nettype none

module ctspf_back (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          head_valid,
  input  ctspf_pkg::frame_t                  head_frame,
  output logic                               pop,
  input  wire logic [ctspf_pkg::COLOR_W-1:0] color_open,
  input  wire logic [ctspf_pkg::COLOR_W-1:0] color_closed,
  input  wire logic [ctspf_pkg::COLOR_W-1:0] color_notice,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [ctspf_pkg::INDEX_W-1:0]      pixel_index,
  output logic [ctspf_pkg::COLOR_W-1:0]      pixel_color,
  output logic                               frame_last
);

  logic [ctspf_pkg::INDEX_W-1:0] pix;
  logic [3:0]                    off;
  logic [1:0]                    slot;
  logic                          adv, lit, last;
  logic [7:0]                    pat;
  logic [ctspf_pkg::COLOR_W-1:0] col;

  assign adv  = head_valid && (!m_tvalid || m_tready);
  assign last = (pix == ctspf_pkg::INDEX_W'(ctspf_pkg::FRAME_PIXELS - 1));
  assign pop  = adv && last;
  assign pat  = head_frame.pat[slot];
  assign lit  = pat[ctspf_pkg::offset_bit(off)];

  // Color of the current digit slot.
  always_comb begin
    case (head_frame.csel[slot])
      ctspf_pkg::CS_OPEN:   col = color_open;
      ctspf_pkg::CS_CLOSED: col = color_closed;
      ctspf_pkg::CS_NOTICE: col = color_notice;
      default:              col = color_notice;
    endcase
  end

  // Pixel position counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      pix  <= '0;
      off  <= '0;
      slot <= '0;
    end else if (adv) begin
      if (last) begin
        pix  <= '0;
        off  <= '0;
        slot <= '0;
      end else begin
        pix <= pix + 1'b1;
        if (off == 4'(ctspf_pkg::PIXELS_PER_DIGIT - 1)) begin
          off  <= '0;
          slot <= slot + 1'b1;
        end else begin
          off <= off + 1'b1;
        end
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pixel_index <= pix;
      pixel_color <= lit ? col : '0;
      frame_last  <= last;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/counter_to_segment_pixel_frame.sv
// Top level of the counter to segment pixel frame block: color registers, front end,
// frame queue and pixel serializer. Depends on ctspf_pkg, ctspf_front, ctspf_queue, ctspf_back.
//
//   Channel  Direction  Words                      Content
//   s_*      in         one count per frame        tdata = count_value, tuser = is_open
//   m_*      out        60 pixels per frame        tdata = pixel_index, pixel_color; tlast
//   cfg_*    in         one register per write     color_open, color_closed, color_notice
//
// The front end handles a count in steps (capture, four divide-by-ten steps, queue
// write); the serializer sends one pixel word per cycle while m_tready does not stall it,
// so the serializer, not the front end, sets the sustained rate of counts.
// Reset (rst, synchronous) empties the queue and restores the reset colors.
// A stall on m_tready holds the output word; the two-entry queue lets the front end
// take the next count while the current frame is still being sent.
`default_nettype none

module counter_to_segment_pixel_frame #(
  parameter int QUEUE_DEPTH = ctspf_pkg::QUEUE_DEPTH
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  input  wire logic [15:0]                     s_tdata,   // [15:0] count_value
  input  wire logic                            s_tuser,   // [0] is_open
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic [31:0]                          m_tdata,   // [5:0] pixel_index, [29:6] pixel_color
  output logic                                 m_tlast,
  input  wire logic                            cfg_we,
  input  wire logic [ctspf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ctspf_pkg::COLOR_W-1:0]   cfg_data
);

  logic [ctspf_pkg::COLOR_W-1:0] color_open, color_closed, color_notice;
  logic                          push, q_full, pop, head_valid;
  ctspf_pkg::frame_t             push_frame, head_frame;
  logic [ctspf_pkg::INDEX_W-1:0] pixel_index;
  logic [ctspf_pkg::COLOR_W-1:0] pixel_color;

  // Color registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      color_open   <= ctspf_pkg::RESET_COLOR_OPEN;
      color_closed <= ctspf_pkg::RESET_COLOR_CLOSED;
      color_notice <= ctspf_pkg::RESET_COLOR_NOTICE;
    end else if (cfg_we) begin
      case (cfg_index)
        ctspf_pkg::CFG_COLOR_OPEN:   color_open   <= cfg_data;
        ctspf_pkg::CFG_COLOR_CLOSED: color_closed <= cfg_data;
        ctspf_pkg::CFG_COLOR_NOTICE: color_notice <= cfg_data;
        default: ;
      endcase
    end
  end

  ctspf_front u_front (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .count_value (s_tdata),
    .is_open     (s_tuser),
    .push        (push),
    .push_frame  (push_frame),
    .q_full      (q_full)
  );

  ctspf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_frame (push_frame),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_frame (head_frame)
  );

  ctspf_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head_frame   (head_frame),
    .pop          (pop),
    .color_open   (color_open),
    .color_closed (color_closed),
    .color_notice (color_notice),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .pixel_index  (pixel_index),
    .pixel_color  (pixel_color),
    .frame_last   (m_tlast)
  );

  assign m_tdata = {2'b00, pixel_color, pixel_index};

endmodule

`default_nettype wire
